// ===== rtl/nric_pkg.sv =====
// shared types and constants for the cubic newton root search
package nric_pkg;

  localparam int FRAC_BITS = 32;
  localparam int VAL_W     = 48;
  localparam int PROD_W    = 2 * VAL_W;
  localparam int EXACT_W   = PROD_W + 1;
  localparam int SUM_W     = PROD_W + 2;
  localparam int DIV_SH    = VAL_W - FRAC_BITS;
  localparam int ITER_W    = 10;
  localparam int TOL_W     = 33;
  localparam int TSQ_W     = 2 * TOL_W;

  localparam logic [2:0] ST_CONV  = 3'd0;
  localparam logic [2:0] ST_EXACT = 3'd1;
  localparam logic [2:0] ST_LIMIT = 3'd2;
  localparam logic [2:0] ST_ZDER  = 3'd3;
  localparam logic [2:0] ST_OVF   = 3'd4;

  localparam logic CFG_MAX_ITER = 1'b0;
  localparam logic CFG_TOL      = 1'b1;

  localparam logic [ITER_W-1:0] MAX_ITER_RST = ITER_W'(200);
  localparam logic [TOL_W-1:0]  TOL_RST      = TOL_W'(4);

  typedef enum logic [4:0] {
    S_IDLE, S_TSQ, S_CHK, S_XX, S_YY, S_XY, S_AX, S_BY, S_AY, S_BX, S_TST,
    S_DRR, S_DII, S_FRDR, S_FIDI, S_FIDR, S_FRDI, S_DVR, S_DVI, S_UPD,
    S_QRR, S_QII
  } state_t;

  function automatic logic fits_val(input logic signed [VAL_W+1:0] v);
    return (v[VAL_W+1:VAL_W-1] == 3'b000) || (v[VAL_W+1:VAL_W-1] == 3'b111);
  endfunction

  function automatic logic signed [VAL_W+1:0] ext_val(input logic signed [VAL_W-1:0] v);
    return {{2{v[VAL_W-1]}}, v};
  endfunction

endpackage

// ===== rtl/nric_mul.sv =====
// iterative 48x48 signed multiplier built from four 24x24 partial products
module nric_mul (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               go,
  input  logic signed [nric_pkg::VAL_W-1:0]  op_a,
  input  logic signed [nric_pkg::VAL_W-1:0]  op_b,
  output logic                               done,
  output logic signed [nric_pkg::VAL_W-1:0]  rnd_val,
  output logic                               rnd_ovf,
  output logic signed [nric_pkg::EXACT_W-1:0] exact
);
  import nric_pkg::*;

  localparam int HALF = VAL_W / 2;

  logic [VAL_W-1:0]  ma_r, mb_r;
  logic              neg_r;
  logic [PROD_W-1:0] acc_r;
  logic [1:0]        step_r;
  logic              busy_r, done_r;

  logic [VAL_W-1:0]   mag_a, mag_b;
  logic [HALF-1:0]    pa, pb;
  logic [VAL_W-1:0]   pp;
  logic [1:0]         sel;
  logic [PROD_W-1:0]  pp_sh;
  logic [EXACT_W-1:0] rsum, rsh, lim;

  assign mag_a = op_a[VAL_W-1] ? VAL_W'(-op_a) : VAL_W'(op_a);
  assign mag_b = op_b[VAL_W-1] ? VAL_W'(-op_b) : VAL_W'(op_b);
  assign pa    = step_r[0] ? ma_r[VAL_W-1:HALF] : ma_r[HALF-1:0];
  assign pb    = step_r[1] ? mb_r[VAL_W-1:HALF] : mb_r[HALF-1:0];
  assign pp    = pa * pb;
  assign sel   = 2'({1'b0, step_r[0]} + {1'b0, step_r[1]});

  always_comb begin
    unique case (sel)
      2'd0:    pp_sh = {{VAL_W{1'b0}}, pp};
      2'd1:    pp_sh = {{HALF{1'b0}}, pp, {HALF{1'b0}}};
      default: pp_sh = {pp, {VAL_W{1'b0}}};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == 2'd3) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      ma_r   <= mag_a;
      mb_r   <= mag_b;
      neg_r  <= op_a[VAL_W-1] ^ op_b[VAL_W-1];
      acc_r  <= '0;
      step_r <= 2'd0;
    end else if (busy_r) begin
      acc_r  <= acc_r + pp_sh;
      step_r <= step_r + 2'd1;
    end
  end

  assign rsum    = {1'b0, acc_r} + (EXACT_W'(1) << (FRAC_BITS - 1));
  assign rsh     = rsum >> FRAC_BITS;
  assign lim     = neg_r ? (EXACT_W'(1) << (VAL_W - 1)) : ((EXACT_W'(1) << (VAL_W - 1)) - 1'b1);
  assign rnd_ovf = rsh > lim;
  assign rnd_val = neg_r ? -$signed(rsh[VAL_W-1:0]) : $signed(rsh[VAL_W-1:0]);
  assign exact   = neg_r ? -$signed({1'b0, acc_r}) : $signed({1'b0, acc_r});
  assign done    = done_r;

endmodule

// ===== rtl/nric_div.sv =====
// bit-serial restoring divider giving a rounded signed fixed-point quotient
module nric_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                go,
  input  logic signed [nric_pkg::SUM_W-1:0]   num,
  input  logic [nric_pkg::EXACT_W-1:0]        den,
  output logic                                done,
  output logic signed [nric_pkg::VAL_W-1:0]   quo,
  output logic                                ovf
);
  import nric_pkg::*;

  logic [EXACT_W-1:0] rem_r, den_r;
  logic [VAL_W-1:0]   lo_r, q_r;
  logic               neg_r, ovf_r, busy_r, done_r;
  logic [5:0]         cnt_r;

  logic [SUM_W-1:0]   mag, r2, diff;
  logic [EXACT_W-1:0] hi;
  logic               ge, rup;
  logic [VAL_W:0]     q49, lim;

  assign mag  = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
  assign hi   = EXACT_W'(mag >> DIV_SH);
  assign r2   = {rem_r, lo_r[VAL_W-1]};
  assign diff = r2 - {1'b0, den_r};
  assign ge   = r2 >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= !(hi >= den);
        done_r <= hi >= den;
      end else if (busy_r && cnt_r == 6'(VAL_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= hi;
      lo_r  <= {mag[DIV_SH-1:0], {FRAC_BITS{1'b0}}};
      den_r <= den;
      neg_r <= num[SUM_W-1];
      ovf_r <= hi >= den;
      q_r   <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[EXACT_W-1:0] : r2[EXACT_W-1:0];
      lo_r  <= {lo_r[VAL_W-2:0], 1'b0};
      q_r   <= {q_r[VAL_W-2:0], ge};
      cnt_r <= cnt_r + 6'd1;
    end
  end

  assign rup  = {rem_r, 1'b0} >= {1'b0, den_r};
  assign q49  = {1'b0, q_r} + (VAL_W+1)'(rup);
  assign lim  = neg_r ? ((VAL_W+1)'(1) << (VAL_W - 1)) : (((VAL_W+1)'(1) << (VAL_W - 1)) - 1'b1);
  assign ovf  = ovf_r || (q49 > lim);
  assign quo  = neg_r ? -$signed(q49[VAL_W-1:0]) : $signed(q49[VAL_W-1:0]);
  assign done = done_r;

endmodule

// ===== rtl/newton_root_iteration_cubic.sv =====
// top level: sequencer around the shared multiplier and divider
// Newton search for a root of z^3 - 1 from a complex start point, signed Q16.32.
// An item is taken at a clock edge with start high and busy low; busy stays high
// until the result is shown. The result appears for exactly one cycle with
// out_valid high; the receiver cannot hold it off, so it must take it then.
// Configuration (cfg_we, cfg_index, cfg_wdata) must be written only while busy
// is low; the block itself does not enforce this. Index 0 is the iteration
// limit, index 1 the step tolerance. Every multiply goes through one 48x48
// unit that takes four 24x24 steps; the divider yields one quotient bit a
// cycle. One Newton step uses 15 products, two quotients and three
// single-cycle states. Items are handled one at a time: a new start point is
// taken only once the last result is shown.
// Synchronous reset returns to idle with limit 200 and tolerance 4.
module newton_root_iteration_cubic (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [nric_pkg::VAL_W-1:0]   in_start_re,
  input  logic signed [nric_pkg::VAL_W-1:0]   in_start_im,
  output logic                                out_valid,
  output logic signed [nric_pkg::VAL_W-1:0]   out_root_re,
  output logic signed [nric_pkg::VAL_W-1:0]   out_root_im,
  output logic [nric_pkg::ITER_W-1:0]         out_iterations,
  output logic [2:0]                          out_status,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [nric_pkg::TOL_W-1:0]          cfg_wdata
);
  import nric_pkg::*;

  localparam logic signed [VAL_W+1:0] ONE_EXT  = (VAL_W+2)'(1) << FRAC_BITS;
  localparam logic [EXACT_W-1:0]      CHG_INIT = EXACT_W'(1) << (2 * FRAC_BITS);

  state_t state_r, state_nxt;
  logic   pend_r, pend_nxt;
  logic signed [VAL_W-1:0] x_r, x_nxt, y_r, y_nxt, a_r, a_nxt, b_r, b_nxt;
  logic signed [VAL_W-1:0] t1_r, t1_nxt, fr_r, fr_nxt, fi_r, fi_nxt;
  logic signed [VAL_W-1:0] dr_r, dr_nxt, di_r, di_nxt, qr_r, qr_nxt, qi_r, qi_nxt;
  logic signed [SUM_W-1:0] acc_r, acc_nxt, nr_r, nr_nxt, ni_r, ni_nxt;
  logic [EXACT_W-1:0]      den_r, den_nxt, chg_r, chg_nxt;
  logic [TSQ_W-1:0]        tsq_r, tsq_nxt;
  logic [ITER_W-1:0]       count_r, count_nxt, maxit_r;
  logic [TOL_W-1:0]        tol_r;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] root_re_r, root_re_nxt, root_im_r, root_im_nxt;
  logic [ITER_W-1:0]       iter_r, iter_nxt;
  logic [2:0]              status_r, status_nxt;

  logic                      mul_go, mul_done, rnd_ovf, div_go, div_done, div_ovf;
  logic signed [VAL_W-1:0]   mop_a, mop_b, rnd, quo;
  logic signed [EXACT_W-1:0] mexact;
  logic signed [SUM_W-1:0]   pex, div_num;

  nric_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (mul_go),
    .op_a    (mop_a),
    .op_b    (mop_b),
    .done    (mul_done),
    .rnd_val (rnd),
    .rnd_ovf (rnd_ovf),
    .exact   (mexact)
  );

  nric_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .num   (div_num),
    .den   (den_r),
    .done  (div_done),
    .quo   (quo),
    .ovf   (div_ovf)
  );

  assign pex     = {mexact[EXACT_W-1], mexact};
  assign div_num = (state_r == S_DVR) ? nr_r : ni_r;

  always_comb begin
    unique case (state_r)
      S_TSQ:   begin mop_a = $signed({{(VAL_W-TOL_W){1'b0}}, tol_r});
                     mop_b = $signed({{(VAL_W-TOL_W){1'b0}}, tol_r}); end
      S_XX:    begin mop_a = x_r;  mop_b = x_r;  end
      S_YY:    begin mop_a = y_r;  mop_b = y_r;  end
      S_XY:    begin mop_a = x_r;  mop_b = y_r;  end
      S_AX:    begin mop_a = a_r;  mop_b = x_r;  end
      S_BY:    begin mop_a = b_r;  mop_b = y_r;  end
      S_AY:    begin mop_a = a_r;  mop_b = y_r;  end
      S_BX:    begin mop_a = b_r;  mop_b = x_r;  end
      S_DRR:   begin mop_a = dr_r; mop_b = dr_r; end
      S_DII:   begin mop_a = di_r; mop_b = di_r; end
      S_FRDR:  begin mop_a = fr_r; mop_b = dr_r; end
      S_FIDI:  begin mop_a = fi_r; mop_b = di_r; end
      S_FIDR:  begin mop_a = fi_r; mop_b = dr_r; end
      S_FRDI:  begin mop_a = fr_r; mop_b = di_r; end
      S_QRR:   begin mop_a = qr_r; mop_b = qr_r; end
      S_QII:   begin mop_a = qi_r; mop_b = qi_r; end
      default: begin mop_a = '0;   mop_b = '0;   end
    endcase
  end

  always_comb begin
    logic                    mdone, fin;
    logic [2:0]              fin_st;
    logic signed [VAL_W+1:0] d, e;
    mdone       = pend_r && mul_done;
    fin         = 1'b0;
    fin_st      = ST_CONV;
    d           = '0;
    e           = '0;
    mul_go      = 1'b0;
    div_go      = 1'b0;
    state_nxt   = state_r;
    pend_nxt    = pend_r;
    x_nxt = x_r;   y_nxt = y_r;   a_nxt = a_r;   b_nxt = b_r;
    t1_nxt = t1_r; fr_nxt = fr_r; fi_nxt = fi_r; dr_nxt = dr_r; di_nxt = di_r;
    qr_nxt = qr_r; qi_nxt = qi_r; acc_nxt = acc_r; nr_nxt = nr_r; ni_nxt = ni_r;
    den_nxt = den_r; chg_nxt = chg_r; tsq_nxt = tsq_r; count_nxt = count_r;
    out_valid_nxt = 1'b0;
    root_re_nxt = root_re_r; root_im_nxt = root_im_r;
    iter_nxt = iter_r; status_nxt = status_r;

    if (state_r != S_IDLE && state_r != S_CHK && state_r != S_TST && state_r != S_UPD
        && !pend_r) begin
      pend_nxt = 1'b1;
      if (state_r == S_DVR || state_r == S_DVI) begin
        div_go = 1'b1;
      end else begin
        mul_go = 1'b1;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          x_nxt     = in_start_re;
          y_nxt     = in_start_im;
          count_nxt = '0;
          chg_nxt   = CHG_INIT;
          pend_nxt  = 1'b0;
          state_nxt = S_TSQ;
        end
      end
      S_TSQ: if (mdone) begin
        pend_nxt  = 1'b0;
        tsq_nxt   = mexact[TSQ_W-1:0];
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (chg_r < {{(EXACT_W-TSQ_W){1'b0}}, tsq_r}) begin
          fin = 1'b1; fin_st = ST_CONV;
        end else begin
          state_nxt = S_XX;
        end
      end
      S_XX, S_AX, S_AY: if (mdone) begin
        pend_nxt = 1'b0;
        t1_nxt   = rnd;
        if (rnd_ovf) begin
          fin = 1'b1; fin_st = ST_OVF;
        end else begin
          state_nxt = (state_r == S_XX) ? S_YY : ((state_r == S_AX) ? S_BY : S_BX);
        end
      end
      S_YY: if (mdone) begin
        pend_nxt = 1'b0;
        d        = ext_val(t1_r) - ext_val(rnd);
        a_nxt    = d[VAL_W-1:0];
        if (rnd_ovf || !fits_val(d)) begin
          fin = 1'b1; fin_st = ST_OVF;
        end else begin
          state_nxt = S_XY;
        end
      end
      S_XY: if (mdone) begin
        pend_nxt = 1'b0;
        d        = ext_val(rnd) + ext_val(rnd);
        b_nxt    = d[VAL_W-1:0];
        if (rnd_ovf || !fits_val(d)) begin
          fin = 1'b1; fin_st = ST_OVF;
        end else begin
          state_nxt = S_AX;
        end
      end
      S_BY: if (mdone) begin
        pend_nxt = 1'b0;
        d        = ext_val(t1_r) - ext_val(rnd);
        e        = ext_val(d[VAL_W-1:0]) - ONE_EXT;
        fr_nxt   = e[VAL_W-1:0];
        if (rnd_ovf || !fits_val(d) || !fits_val(e)) begin
          fin = 1'b1; fin_st = ST_OVF;
        end else begin
          state_nxt = S_AY;
        end
      end
      S_BX: if (mdone) begin
        pend_nxt = 1'b0;
        d        = ext_val(t1_r) + ext_val(rnd);
        fi_nxt   = d[VAL_W-1:0];
        if (rnd_ovf || !fits_val(d)) begin
          fin = 1'b1; fin_st = ST_OVF;
        end else begin
          state_nxt = S_TST;
        end
      end
      S_TST: begin
        d      = ext_val(a_r) + ext_val(a_r) + ext_val(a_r);
        e      = ext_val(b_r) + ext_val(b_r) + ext_val(b_r);
        dr_nxt = d[VAL_W-1:0];
        di_nxt = e[VAL_W-1:0];
        if (!fits_val(d) || !fits_val(e)) begin
          fin = 1'b1; fin_st = ST_OVF;
        end else if (fr_r == '0 && fi_r == '0) begin
          fin = 1'b1; fin_st = ST_EXACT;
        end else if (count_r >= maxit_r) begin
          fin = 1'b1; fin_st = ST_LIMIT;
        end else begin
          count_nxt = count_r + 1'b1;
          if (a_r == '0 && b_r == '0) begin
            fin = 1'b1; fin_st = ST_ZDER;
          end else begin
            state_nxt = S_DRR;
          end
        end
      end
      S_DRR, S_FRDR, S_FIDR, S_QRR: if (mdone) begin
        pend_nxt = 1'b0;
        acc_nxt  = pex;
        unique case (state_r)
          S_DRR:   state_nxt = S_DII;
          S_FRDR:  state_nxt = S_FIDI;
          S_FIDR:  state_nxt = S_FRDI;
          default: state_nxt = S_QII;
        endcase
      end
      S_DII: if (mdone) begin
        pend_nxt  = 1'b0;
        den_nxt   = acc_r[EXACT_W-1:0] + mexact[EXACT_W-1:0];
        state_nxt = S_FRDR;
      end
      S_FIDI: if (mdone) begin
        pend_nxt  = 1'b0;
        nr_nxt    = acc_r + pex;
        state_nxt = S_FIDR;
      end
      S_FRDI: if (mdone) begin
        pend_nxt  = 1'b0;
        ni_nxt    = acc_r - pex;
        state_nxt = S_DVR;
      end
      S_DVR, S_DVI: if (pend_r && div_done) begin
        pend_nxt = 1'b0;
        if (state_r == S_DVR) qr_nxt = quo;
        else                  qi_nxt = quo;
        if (div_ovf) begin
          fin = 1'b1; fin_st = ST_OVF;
        end else begin
          state_nxt = (state_r == S_DVR) ? S_DVI : S_UPD;
        end
      end
      S_UPD: begin
        d = ext_val(x_r) - ext_val(qr_r);
        e = ext_val(y_r) - ext_val(qi_r);
        if (!fits_val(d) || !fits_val(e)) begin
          fin = 1'b1; fin_st = ST_OVF;
        end else begin
          x_nxt     = d[VAL_W-1:0];
          y_nxt     = e[VAL_W-1:0];
          state_nxt = S_QRR;
        end
      end
      S_QII: if (mdone) begin
        pend_nxt  = 1'b0;
        chg_nxt   = acc_r[EXACT_W-1:0] + mexact[EXACT_W-1:0];
        state_nxt = S_CHK;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (fin) begin
      out_valid_nxt = 1'b1;
      root_re_nxt   = x_r;
      root_im_nxt   = y_r;
      iter_nxt      = count_nxt;
      status_nxt    = fin_st;
      pend_nxt      = 1'b0;
      state_nxt     = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      maxit_r     <= MAX_ITER_RST;
      tol_r       <= TOL_RST;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MAX_ITER: maxit_r <= cfg_wdata[ITER_W-1:0];
          CFG_TOL:      tol_r   <= cfg_wdata;
          default:      ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;     y_r <= y_nxt;     a_r <= a_nxt;     b_r <= b_nxt;
    t1_r <= t1_nxt;   fr_r <= fr_nxt;   fi_r <= fi_nxt;
    dr_r <= dr_nxt;   di_r <= di_nxt;   qr_r <= qr_nxt;   qi_r <= qi_nxt;
    acc_r <= acc_nxt; nr_r <= nr_nxt;   ni_r <= ni_nxt;
    den_r <= den_nxt; chg_r <= chg_nxt; tsq_r <= tsq_nxt; count_r <= count_nxt;
    root_re_r <= root_re_nxt;
    root_im_r <= root_im_nxt;
    iter_r    <= iter_nxt;
    status_r  <= status_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_root_re    = root_re_r;
  assign out_root_im    = root_im_r;
  assign out_iterations = iter_r;
  assign out_status     = status_r;

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the cubic newton root search block
`timescale 1ns / 100ps

module tb_top;
  import nric_pkg::*;

  localparam longint ONE_FX  = 64'sd1 <<< FRAC_BITS;
  localparam longint MAX_FX  = 64'sd140737488355327;
  localparam longint MIN_FX  = -64'sd140737488355328;
  localparam int     WD_LIMIT = 1000000;
  localparam int     N_PHASES = 12;
  localparam int     PER_PHASE = 50;

  typedef struct packed {
    logic signed [VAL_W-1:0] re;
    logic signed [VAL_W-1:0] im;
    logic [ITER_W-1:0]       it;
    logic [2:0]              st;
  } root_t;

  typedef struct {
    int          mi;
    longint      tol;
    longint      re;
    longint      im;
    bit          typed;
    root_t       exp_res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [VAL_W-1:0] in_start_re = '0;
  logic signed [VAL_W-1:0] in_start_im = '0;
  logic out_valid;
  logic signed [VAL_W-1:0] out_root_re;
  logic signed [VAL_W-1:0] out_root_im;
  logic [ITER_W-1:0] out_iterations;
  logic [2:0] out_status;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [TOL_W-1:0] cfg_wdata = '0;

  root_t pending_roots[$];
  int iter_limit;
  logic [TOL_W-1:0] step_tol;
  int n_mismatch = 0;
  int n_results = 0;
  int n_sent = 0;
  int n_cfg = 0;
  int status_hist[5];
  int idle_cycles = 0;

  always #6 clk = ~clk;

  newton_root_iteration_cubic DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_start_re(in_start_re), .in_start_im(in_start_im),
    .out_valid(out_valid), .out_root_re(out_root_re), .out_root_im(out_root_im),
    .out_iterations(out_iterations), .out_status(out_status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  function automatic longint fit_val(input longint v, inout bit ovf);
    if (v > MAX_FX || v < MIN_FX) begin
      ovf = 1'b1;
      return 0;
    end
    return v;
  endfunction

  function automatic longint from_mag(input bit neg, input logic [191:0] m, inout bit ovf);
    logic [191:0] lim;
    lim = neg ? 192'h800000000000 : 192'h7FFFFFFFFFFF;
    if (m > lim) begin
      ovf = 1'b1;
      return 0;
    end
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic longint round_mul(input longint a, input longint b, inout bit ovf);
    logic [191:0] ma, mb, m;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    m = (ma * mb + (192'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return from_mag((a < 0) != (b < 0), m, ovf);
  endfunction

  function automatic longint round_div(input logic signed [127:0] num,
                                       input logic [127:0] den, inout bit ovf);
    logic [191:0] r, d, q, rm;
    bit neg;
    neg = num < 0;
    r = neg ? -num : num;
    r = r << FRAC_BITS;
    d = den;
    if (r >= (d << VAL_W)) begin
      ovf = 1'b1;
      return 0;
    end
    q = r / d;
    rm = r - q * d;
    if ((rm << 1) >= d) q = q + 1;
    return from_mag(neg, q, ovf);
  endfunction

  function automatic root_t newton_predict(input longint sx, input longint sy);
    longint x, y, a, b, cr, ci, fr, fi, dr, di, qr, qi, nx, ny;
    logic [127:0] chg, tsq, den;
    logic signed [127:0] nr, ni;
    int cnt;
    bit ovf;
    root_t r;
    x = sx;
    y = sy;
    cnt = 0;
    chg = 128'd1 << (2 * FRAC_BITS);
    tsq = 128'(step_tol) * 128'(step_tol);
    forever begin
      ovf = 1'b0;
      if (chg < tsq) begin
        r.st = ST_CONV;
        break;
      end
      a = fit_val(round_mul(x, x, ovf) - round_mul(y, y, ovf), ovf);
      b = fit_val(2 * round_mul(x, y, ovf), ovf);
      cr = fit_val(round_mul(a, x, ovf) - round_mul(b, y, ovf), ovf);
      ci = fit_val(round_mul(a, y, ovf) + round_mul(b, x, ovf), ovf);
      fr = fit_val(cr - ONE_FX, ovf);
      fi = ci;
      dr = fit_val(3 * a, ovf);
      di = fit_val(3 * b, ovf);
      if (ovf) begin
        r.st = ST_OVF;
        break;
      end
      if (fr == 0 && fi == 0) begin
        r.st = ST_EXACT;
        break;
      end
      if (cnt >= iter_limit) begin
        r.st = ST_LIMIT;
        break;
      end
      cnt++;
      if (dr == 0 && di == 0) begin
        r.st = ST_ZDER;
        break;
      end
      den = 128'(dr) * 128'(dr) + 128'(di) * 128'(di);
      nr = 128'(fr) * 128'(dr) + 128'(fi) * 128'(di);
      ni = 128'(fi) * 128'(dr) - 128'(fr) * 128'(di);
      qr = round_div(nr, den, ovf);
      qi = round_div(ni, den, ovf);
      nx = fit_val(x - qr, ovf);
      ny = fit_val(y - qi, ovf);
      if (ovf) begin
        r.st = ST_OVF;
        break;
      end
      x = nx;
      y = ny;
      chg = 128'(qr) * 128'(qr) + 128'(qi) * 128'(qi);
    end
    r.re = x[VAL_W-1:0];
    r.im = y[VAL_W-1:0];
    r.it = cnt[ITER_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      root_t e;
      n_results++;
      if (pending_roots.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected result: re %h im %h it %0d st %0d",
                   out_root_re, out_root_im, out_iterations, out_status);
      end else begin
        e = pending_roots.pop_front();
        if (out_status <= ST_OVF) status_hist[out_status]++;
        if (out_root_re !== e.re || out_root_im !== e.im ||
            out_iterations !== e.it || out_status !== e.st) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: exp re %h im %h it %0d st %0d / got re %h im %h it %0d st %0d",
                     e.re, e.im, e.it, e.st,
                     out_root_re, out_root_im, out_iterations, out_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WD_LIMIT);
      $display("newton_root_iteration_cubic regression: fail");
      $finish;
    end
  end

  task automatic send_point(input longint re, input longint im, input int gap,
                            input bit typed, input root_t typed_res);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_start_re <= re[VAL_W-1:0];
    in_start_im <= im[VAL_W-1:0];
    do @(posedge clk); while (busy);
    pending_roots.push_back(typed ? typed_res : newton_predict(re, im));
    n_sent++;
  endtask

  task automatic drain;
    start <= 1'b0;
    do @(posedge clk); while (pending_roots.size() != 0 || busy);
  endtask

  task automatic write_reg(input logic idx, input logic [TOL_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MAX_ITER) iter_limit = int'(val[ITER_W-1:0]);
    else step_tol = val;
    n_cfg++;
  endtask

  task automatic set_config(input int mi, input longint tol);
    if (mi != iter_limit || tol[TOL_W-1:0] != step_tol) begin
      drain();
      if (mi != iter_limit) write_reg(CFG_MAX_ITER, TOL_W'(mi));
      if (tol[TOL_W-1:0] != step_tol) write_reg(CFG_TOL, tol[TOL_W-1:0]);
    end
  endtask

  function automatic root_t mk(input longint re, input longint im, input int it,
                               input logic [2:0] st);
    root_t r;
    r.re = re[VAL_W-1:0];
    r.im = im[VAL_W-1:0];
    r.it = it[ITER_W-1:0];
    r.st = st;
    return r;
  endfunction

  function automatic longint rand_wide(input int bits);
    logic [63:0] v;
    v = {$urandom, $urandom};
    v = v & ((64'd1 << bits) - 1);
    if (v[bits-1]) v = v | ~((64'd1 << bits) - 1);
    return longint'(v);
  endfunction

  function automatic longint rand_start(input bit im_part);
    int k;
    k = $urandom_range(0, 9);
    case (k)
      0: return rand_wide(VAL_W);
      1: return rand_wide($urandom_range(1, 20));
      2: return (im_part ? 0 : ONE_FX) + rand_wide($urandom_range(1, 30));
      3: return (im_part ? 64'sd3719550786 : -(ONE_FX >>> 1)) + rand_wide(28);
      default: return rand_wide($urandom_range(33, 36));
    endcase
  endfunction

  stim_row_t directed[$];
  root_t no_res;

  initial begin
    int mi;
    longint tol;
    stim_row_t row;
    no_res = '0;
    iter_limit = int'(MAX_ITER_RST);
    step_tol = TOL_RST;
    foreach (status_hist[i]) status_hist[i] = 0;

    // directed rows after reset and at register extremes
    directed.push_back('{200, 4, ONE_FX, 0, 1, mk(ONE_FX, 0, 0, ST_EXACT)});
    directed.push_back('{200, 4, 0, 0, 1, mk(0, 0, 1, ST_ZDER)});
    directed.push_back('{200, 4, 1, 1, 1, mk(1, 1, 1, ST_ZDER)});
    directed.push_back('{200, 4, -1, -1, 1, mk(-1, -1, 1, ST_ZDER)});
    directed.push_back('{200, 4, MAX_FX, MAX_FX, 1, mk(MAX_FX, MAX_FX, 0, ST_OVF)});
    directed.push_back('{200, 4, MIN_FX, MIN_FX, 1, mk(MIN_FX, MIN_FX, 0, ST_OVF)});
    directed.push_back('{200, 4, MIN_FX, 0, 1, mk(MIN_FX, 0, 0, ST_OVF)});
    directed.push_back('{200, 4, 0, MAX_FX, 1, mk(0, MAX_FX, 0, ST_OVF)});
    directed.push_back('{200, 4, -ONE_FX, 0, 0, no_res});
    directed.push_back('{200, 4, 0, ONE_FX, 0, no_res});
    directed.push_back('{200, 4, 2 * ONE_FX, 3 * ONE_FX, 0, no_res});
    directed.push_back('{200, 4, ONE_FX / 100, -ONE_FX / 7, 0, no_res});
    directed.push_back('{0, 4, 2 * ONE_FX, 0, 1, mk(2 * ONE_FX, 0, 0, ST_LIMIT)});
    directed.push_back('{0, 4, ONE_FX, 0, 1, mk(ONE_FX, 0, 0, ST_EXACT)});
    directed.push_back('{1, 4, 0, 0, 1, mk(0, 0, 1, ST_ZDER)});
    directed.push_back('{1, 4, 3 * ONE_FX, ONE_FX, 0, no_res});
    directed.push_back('{200, ONE_FX + 1, 3 * ONE_FX, ONE_FX, 1,
                         mk(3 * ONE_FX, ONE_FX, 0, ST_CONV)});
    directed.push_back('{200, 64'h1FFFFFFFF, MAX_FX, MIN_FX, 1,
                         mk(MAX_FX, MIN_FX, 0, ST_CONV)});
    directed.push_back('{200, ONE_FX, 3 * ONE_FX, ONE_FX, 0, no_res});
    directed.push_back('{200, 0, -ONE_FX / 2, ONE_FX / 3, 0, no_res});
    directed.push_back('{1023, 0, 3 * ONE_FX / 2, ONE_FX / 3, 0, no_res});
    directed.push_back('{1023, 1 << 20, -5 * ONE_FX, 7 * ONE_FX, 0, no_res});

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      row = directed[i];
      set_config(row.mi, row.tol);
      send_point(row.re, row.im, $urandom_range(0, 5), row.typed, row.exp_res);
    end

    // out-of-range write keeps only the low bits of the limit
    drain();
    write_reg(CFG_MAX_ITER, 33'h100000005);
    send_point(2 * ONE_FX, ONE_FX, 0, 0, no_res);

    for (int p = 0; p < N_PHASES; p++) begin
      case ($urandom_range(0, 5))
        0: mi = 0;
        1: mi = $urandom_range(1, 3);
        2: mi = 200;
        default: mi = $urandom_range(4, 25);
      endcase
      case ($urandom_range(0, 6))
        0: tol = 0;
        1: tol = 1;
        2: tol = 4;
        3: tol = ONE_FX + $urandom_range(0, 3);
        4: tol = 64'h1FFFFFFFF;
        default: tol = $urandom_range(1, 1 << 24);
      endcase
      if (p == 0) mi = 0;
      if (p == 1) tol = 0;
      set_config(mi, tol);
      for (int k = 0; k < PER_PHASE; k++) begin
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
        if (p == 3) gap = 0;
        send_point(rand_start(1'b0), rand_start(1'b1), gap, 0, no_res);
      end
    end

    drain();
    repeat (100) @(posedge clk);
    $display("sent %0d start points over %0d register writes, %0d results checked",
             n_sent, n_cfg, n_results);
    $display("status mix: conv %0d exact %0d limit %0d zero-deriv %0d overflow %0d",
             status_hist[0], status_hist[1], status_hist[2], status_hist[3],
             status_hist[4]);
    if (n_mismatch == 0 && pending_roots.size() == 0) begin
      $display("newton_root_iteration_cubic regression: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", n_mismatch, pending_roots.size());
      $display("newton_root_iteration_cubic regression: fail");
    end
    $finish;
  end

endmodule
